// ===== design/dsgcb_pkg.sv =====
// Package for the DMA scatter-gather chain builder.
// Item types, field codes and sizing constants; no dependencies.
package dsgcb_pkg;

  // Page and transfer limits (page size is a power of two)
  localparam int unsigned PAGE_BYTES    = 4096;
  localparam int unsigned MAX_TRANSFER  = 65536;
  localparam int unsigned COUNT16_LIMIT = 65536;
  localparam int unsigned PAGE_W        = $clog2(PAGE_BYTES);

  // Field widths
  localparam int unsigned CNT_W  = 17;
  localparam int unsigned ADDR_W = 32;

  // Result queue sizing
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned FCNT_W     = $clog2(FIFO_DEPTH + 1);

  // Commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_FRAG  = 1'b1;

  // Transfer unit codes
  localparam logic [1:0] WIDTH_BYTE = 2'd0;
  localparam logic [1:0] WIDTH_WORD = 2'd1;
  localparam logic [1:0] WIDTH_LONG = 2'd2;
  localparam logic [1:0] WIDTH_ALT  = 2'd3;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_COUNT = 2'd1,
    ERR_LONG  = 2'd2,
    ERR_IDLE  = 2'd3
  } err_e;

  typedef struct packed {
    logic              command;
    logic [CNT_W-1:0]  total_count;
    logic [1:0]        width_mode;
    logic              read_dir;
    logic              priority_req;
    logic              no_interrupt;
    logic [ADDR_W-1:0] phys_addr;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] seg_addr;
    logic [CNT_W-1:0]  seg_count;
    logic              dir_write;
    logic [1:0]        unit_width;
    logic              prio_flag;
    logic              intr_enable;
    logic              last_segment;
    err_e              error_code;
  } out_t;

  // Transfer flags latched on start
  typedef struct packed {
    logic       no_interrupt;
    logic       priority_req;
    logic       read_dir;
    logic [1:0] width;
  } mode_t;

endpackage

// ===== design/dma_scatter_gather_chain_builder_unit.sv =====
// Top level of the DMA scatter-gather chain builder.
// Uses dsgcb_pkg for item types, codes and sizing constants.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i): a start item arms a
//   transfer; each fragment item gives the address of the next page piece.
//   Output channel (out_valid_o / out_stall_i / out_data_o): finished
//   segments and error items, in order.
//   cfg_we_i / cfg_wdata_i write the 16-bit-card flag; write only when idle.
// Timing:
//   An item is worked on in the cycle it is accepted; its zero, one or two
//   results are registered into a four-entry result queue, whose head drives
//   the output. One item is accepted per cycle while the queue has room for
//   two results; an item that yields two results keeps the sustained rate at
//   one item per cycle only if the output drains two per item, so the queue
//   drain rate of at most one result per cycle sets the limit.
// Reset:
//   Clears the transfer state, the flag register and the queue.
// Stall:
//   A stalled output holds its item; in_stall_o rises once fewer than two
//   queue entries are free.
module dma_scatter_gather_chain_builder_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  dsgcb_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output dsgcb_pkg::out_t out_data_o,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i
);
  import dsgcb_pkg::*;

  // Transfer state
  logic              card16_q;
  logic              active_q, active_d;
  logic              pend_valid_q, pend_valid_d;
  logic [CNT_W-1:0]  remain_q, remain_d;
  logic [ADDR_W-1:0] pend_addr_q, pend_addr_d;
  logic [CNT_W-1:0]  pend_units_q, pend_units_d;
  logic [ADDR_W-1:0] pend_end_q, pend_end_d;
  mode_t             mode_q, mode_d;

  // Result queue
  out_t              fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  head_q, tail_q;
  logic [FCNT_W-1:0] fcnt_q;

  logic       accept, pop;
  logic [1:0] n_push;
  out_t       res0, res1;

  // Fragment datapath
  logic [1:0]        start_w;
  logic [CNT_W-1:0]  page_off, piece, bytes, units;
  logic [CNT_W:0]    merged_sum;
  logic              merge;
  logic [CNT_W-1:0]  remain_next;

  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (fcnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_data_o  = fifo_q[head_q];
  assign in_stall_o  = (fcnt_q > FCNT_W'(FIFO_DEPTH - 2));

  // Piece length: up to the page boundary, clipped by the remaining count
  assign page_off    = {{(CNT_W - PAGE_W){1'b0}}, in_data_i.phys_addr[PAGE_W-1:0]};
  assign piece       = CNT_W'(PAGE_BYTES) - page_off;
  assign bytes       = (remain_q < piece) ? remain_q : piece;
  assign remain_next = remain_q - bytes;
  assign start_w     = (in_data_i.width_mode == WIDTH_ALT) ? WIDTH_LONG
                                                           : in_data_i.width_mode;
  assign merged_sum  = {1'b0, pend_units_q} + {1'b0, units};
  assign merge       = pend_valid_q && (in_data_i.phys_addr == pend_end_q) &&
                       (!card16_q || (merged_sum <= (CNT_W+1)'(COUNT16_LIMIT)));

  // Convert bytes to transfer units
  always_comb begin
    case (mode_q.width)
      WIDTH_LONG: units = bytes >> 2;
      WIDTH_WORD: units = bytes >> 1;
      default:    units = bytes;
    endcase
  end

  // Build a segment item from the current flags
  function automatic out_t make_seg(logic [ADDR_W-1:0] addr, logic [CNT_W-1:0] cnt,
                                    logic last, mode_t m);
    out_t r;
    r.seg_addr     = addr;
    r.seg_count    = cnt;
    r.dir_write    = !m.read_dir;
    r.unit_width   = m.width;
    r.prio_flag    = m.priority_req;
    r.intr_enable  = !(last && m.no_interrupt);
    r.last_segment = last;
    r.error_code   = ERR_OK;
    return r;
  endfunction

  function automatic out_t make_err(err_e e);
    out_t r;
    r            = '0;
    r.error_code = e;
    return r;
  endfunction

  // Work out the next state and the results of the accepted item
  always_comb begin
    active_d     = active_q;
    pend_valid_d = pend_valid_q;
    remain_d     = remain_q;
    pend_addr_d  = pend_addr_q;
    pend_units_d = pend_units_q;
    pend_end_d   = pend_end_q;
    mode_d       = mode_q;
    n_push       = 2'd0;
    res0         = '0;
    res1         = '0;
    if (accept) begin
      if (in_data_i.command == CMD_START) begin
        active_d     = 1'b0;
        pend_valid_d = 1'b0;
        if (in_data_i.total_count == '0 ||
            {{(32 - CNT_W){1'b0}}, in_data_i.total_count} > 32'(MAX_TRANSFER)) begin
          res0   = make_err(ERR_COUNT);
          n_push = 2'd1;
        end else if (start_w == WIDTH_LONG && card16_q) begin
          res0   = make_err(ERR_LONG);
          n_push = 2'd1;
        end else begin
          mode_d.width        = start_w;
          mode_d.read_dir     = in_data_i.read_dir;
          mode_d.priority_req = in_data_i.priority_req;
          mode_d.no_interrupt = in_data_i.no_interrupt;
          remain_d            = in_data_i.total_count;
          pend_units_d        = '0;
          pend_addr_d         = '0;
          pend_end_d          = '0;
          active_d            = 1'b1;
        end
      end else if (!active_q) begin
        res0   = make_err(ERR_IDLE);
        n_push = 2'd1;
      end else begin
        remain_d = remain_next;
        // Merge a contiguous piece (within the 16-bit-card limit), else flush the pending segment
        if (merge) begin
          pend_units_d = merged_sum[CNT_W-1:0];
          pend_end_d   = pend_end_q + {{(ADDR_W - CNT_W){1'b0}}, bytes};
        end else begin
          if (pend_valid_q) begin
            res0   = make_seg(pend_addr_q, pend_units_q, 1'b0, mode_q);
            n_push = 2'd1;
          end
          pend_addr_d  = in_data_i.phys_addr;
          pend_units_d = units;
          pend_end_d   = in_data_i.phys_addr + {{(ADDR_W - CNT_W){1'b0}}, bytes};
          pend_valid_d = 1'b1;
        end
        // Close the chain when the count is used up
        if (remain_next == '0) begin
          if (n_push == 2'd1) begin
            res1   = make_seg(pend_addr_d, pend_units_d, 1'b1, mode_q);
            n_push = 2'd2;
          end else begin
            res0   = make_seg(pend_addr_d, pend_units_d, 1'b1, mode_q);
            n_push = 2'd1;
          end
          pend_valid_d = 1'b0;
          active_d     = 1'b0;
        end
      end
    end
  end

  // Hold the transfer state and flag register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      card16_q     <= 1'b0;
      active_q     <= 1'b0;
      pend_valid_q <= 1'b0;
      remain_q     <= '0;
      pend_addr_q  <= '0;
      pend_units_q <= '0;
      pend_end_q   <= '0;
      mode_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        card16_q <= cfg_wdata_i;
      end
      active_q     <= active_d;
      pend_valid_q <= pend_valid_d;
      remain_q     <= remain_d;
      pend_addr_q  <= pend_addr_d;
      pend_units_q <= pend_units_d;
      pend_end_q   <= pend_end_d;
      mode_q       <= mode_d;
    end
  end

  // Advance the queue pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fcnt_q <= '0;
    end else begin
      if (pop) begin
        head_q <= head_q + PTR_W'(1);
      end
      tail_q <= tail_q + PTR_W'(n_push);
      fcnt_q <= fcnt_q + FCNT_W'(n_push) - FCNT_W'(pop);
    end
  end

  // Write results into the queue
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      fifo_q[tail_q] <= res0;
    end
    if (n_push == 2'd2) begin
      fifo_q[tail_q + PTR_W'(1)] <= res1;
    end
  end

endmodule
